@@ design/baas_pkg.sv @@
// bond axis-angle setup: shared widths, constants and the item carried down the pipe
// no dependencies; used by bond_axis_angle_setup
package baas_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int POS_W       = 24;
   localparam int ID_W        = 16;
   localparam int THR_W       = 17;
   localparam int UNIT_W      = 18;
   localparam int ANGLE_W     = 19;
   localparam int OUT_LEN_W   = 25;
   localparam logic [THR_W-1:0] THR_RESET = THR_W'(65470);

   localparam int DIFF_W      = POS_W + 1;
   localparam int SS_W        = 2 * DIFF_W;
   localparam int LEN_STEPS   = SS_W / 2;
   localparam int LEN_W       = LEN_STEPS + 1;
   localparam int QUO_BITS    = FRAC_BITS + 1;
   localparam int DIVR_W      = LEN_W + FRAC_BITS;

   localparam int ACOS_W      = 62;
   localparam int ACOS_STEPS  = ACOS_W / 2;
   localparam int ACOS_SHIFT  = 60 - 2 * FRAC_BITS;
   localparam int Z_SHIFT     = 30 - FRAC_BITS;
   localparam int ZSQ_W       = 2 * QUO_BITS;
   localparam int CORDIC_STEPS = 31;
   localparam int CRD_W       = 34;
   localparam int ANG_W       = 64;

   localparam logic signed [ANG_W-1:0] PI_Q60      = 64'sh3243F6A8885A308D;
   localparam logic signed [ANG_W-1:0] HALF_PI_Q60 = PI_Q60 / 2;
   localparam logic signed [ANG_W-1:0] QUARTER_PI_Q60 = PI_Q60 / 4;
   localparam logic signed [ANG_W-1:0] ANG_ROUND = 64'sd1 <<< (59 - FRAC_BITS);
   localparam logic signed [ANGLE_W-1:0] POLE_NEG_ANGLE =
      ANGLE_W'(-((PI_Q60 + ANG_ROUND) >>> (60 - FRAC_BITS)));
   localparam logic signed [UNIT_W-1:0] UNIT_ONE = UNIT_W'(1) << FRAC_BITS;

   typedef struct packed {
      logic [ID_W-1:0]          first_id;
      logic [ID_W-1:0]          second_id;
      logic signed [DIFF_W-1:0] dx;
      logic signed [DIFF_W-1:0] dy;
      logic signed [DIFF_W-1:0] dz;
      logic [LEN_W-1:0]         len;
      logic signed [UNIT_W-1:0] ux;
      logic signed [UNIT_W-1:0] uy;
      logic signed [UNIT_W-1:0] uz;
      logic                     pole;
      logic                     pole_neg;
   } item_type;

   // shift-subtract quotient, used only while building constants
   function automatic logic [63:0] const_quot(logic [63:0] n, logic [63:0] d);
      logic [63:0] q;
      logic [64:0] r;
      q = '0;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         r = {r[63:0], n[b]};
         if (r >= {1'b0, d}) begin
            r = r - {1'b0, d};
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   // atan(2^-i) in q60 by its taylor series
   function automatic logic signed [ANG_W-1:0] atan_q60(int i);
      logic signed [ANG_W-1:0] sum;
      logic [63:0] p;
      logic [63:0] t;
      sum = '0;
      if (i == 0) begin
         sum = QUARTER_PI_Q60;
      end else begin
         p = 64'd1 << (60 - i);
         for (int k = 0; k < 64; k++) begin
            if (p != 0) begin
               t = const_quot(p, 64'(2 * k + 1));
               if (k % 2 == 1) sum = sum - signed'(t);
               else            sum = sum + signed'(t);
               p = p >> (2 * i);
            end
         end
      end
      return sum;
   endfunction

endpackage

@@ design/bond_axis_angle_setup.sv @@
// bond axis-angle setup top level: bond length, unit direction, axis and angle
// depends on baas_pkg
//
//  channel | ports                 | handshake
//  --------+-----------------------+-----------------------------------
//  request | start, busy, req_*    | word taken when start and not busy
//  result  | rsp_valid, rsp_*      | one-cycle strobe, cannot be held off
//  csr     | csr_valid, csr_ready  | pole threshold, written on valid/ready
//
// fully pipelined: one word accepted per cycle, and every word reaches rsp_valid in order.
// the depth is set by the length square root (25 steps), the three
// direction dividers (17 steps), the acos root (31 steps) and cordic (31).
// busy stays low; a synchronous reset clears the valid bits and reloads the
// pole threshold.
module bond_axis_angle_setup (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [baas_pkg::POS_W-1:0]    req_first_x,
   input  logic signed [baas_pkg::POS_W-1:0]    req_first_y,
   input  logic signed [baas_pkg::POS_W-1:0]    req_first_z,
   input  logic signed [baas_pkg::POS_W-1:0]    req_second_x,
   input  logic signed [baas_pkg::POS_W-1:0]    req_second_y,
   input  logic signed [baas_pkg::POS_W-1:0]    req_second_z,
   input  logic [baas_pkg::ID_W-1:0]            req_first_atom_id,
   input  logic [baas_pkg::ID_W-1:0]            req_second_atom_id,
   output logic                                 rsp_valid,
   output logic [baas_pkg::OUT_LEN_W-1:0]       rsp_bond_length,
   output logic signed [baas_pkg::UNIT_W-1:0]   rsp_dir_x,
   output logic signed [baas_pkg::UNIT_W-1:0]   rsp_dir_y,
   output logic signed [baas_pkg::UNIT_W-1:0]   rsp_dir_z,
   output logic signed [baas_pkg::UNIT_W-1:0]   rsp_axis_x,
   output logic signed [baas_pkg::UNIT_W-1:0]   rsp_axis_y,
   output logic signed [baas_pkg::UNIT_W-1:0]   rsp_axis_z,
   output logic signed [baas_pkg::ANGLE_W-1:0]  rsp_rot_angle,
   output logic [baas_pkg::ID_W-1:0]            rsp_out_first_id,
   output logic [baas_pkg::ID_W-1:0]            rsp_out_second_id,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [baas_pkg::THR_W-1:0]           csr_data
);

   localparam int SS_W     = baas_pkg::SS_W;
   localparam int LSTEPS   = baas_pkg::LEN_STEPS;
   localparam int LEN_W    = baas_pkg::LEN_W;
   localparam int QBITS    = baas_pkg::QUO_BITS;
   localparam int DIVR_W   = baas_pkg::DIVR_W;
   localparam int ACOS_W   = baas_pkg::ACOS_W;
   localparam int ASTEPS   = baas_pkg::ACOS_STEPS;
   localparam int CSTEPS   = baas_pkg::CORDIC_STEPS;
   localparam int CRD_W    = baas_pkg::CRD_W;
   localparam int ANG_W    = baas_pkg::ANG_W;
   localparam int UNIT_W   = baas_pkg::UNIT_W;
   localparam int FRAC     = baas_pkg::FRAC_BITS;
   localparam int DIFF_W   = baas_pkg::DIFF_W;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // pole threshold register
   logic [baas_pkg::THR_W-1:0] thr_ff;
   always_ff @(posedge clock) begin
      if (reset) thr_ff <= baas_pkg::THR_RESET;
      else if (csr_valid) thr_ff <= csr_data;
   end

   // stage a: bond vector
   baas_pkg::item_type a_item_ff, a_item_in;
   logic               a_vld_ff;
   always_comb begin
      a_item_in           = '0;
      a_item_in.first_id  = req_first_atom_id;
      a_item_in.second_id = req_second_atom_id;
      a_item_in.dx        = DIFF_W'(req_second_x) - DIFF_W'(req_first_x);
      a_item_in.dy        = DIFF_W'(req_second_y) - DIFF_W'(req_first_y);
      a_item_in.dz        = DIFF_W'(req_second_z) - DIFF_W'(req_first_z);
   end
   always_ff @(posedge clock) begin
      if (reset) a_vld_ff <= 1'b0;
      else a_vld_ff <= start;
   end
   always_ff @(posedge clock) begin
      a_item_ff <= a_item_in;
   end

   // stage b: squares
   baas_pkg::item_type b_item_ff;
   logic               b_vld_ff;
   logic signed [SS_W-1:0] b_sqx_ff, b_sqy_ff, b_sqz_ff;
   logic signed [SS_W-1:0] b_sqx_in, b_sqy_in, b_sqz_in;
   always_comb begin
      b_sqx_in = a_item_ff.dx * a_item_ff.dx;
      b_sqy_in = a_item_ff.dy * a_item_ff.dy;
      b_sqz_in = a_item_ff.dz * a_item_ff.dz;
   end
   always_ff @(posedge clock) begin
      if (reset) b_vld_ff <= 1'b0;
      else b_vld_ff <= a_vld_ff;
   end
   always_ff @(posedge clock) begin
      b_item_ff <= a_item_ff;
      b_sqx_ff  <= b_sqx_in;
      b_sqy_ff  <= b_sqy_in;
      b_sqz_ff  <= b_sqz_in;
   end

   // length square root, one result bit per stage; index 0 holds the sum
   logic [SS_W-1:0]         sq_v_ff    [LSTEPS+1];
   logic [SS_W:0]           sq_r_ff    [LSTEPS+1];
   baas_pkg::item_type      sq_item_ff [LSTEPS+1];
   logic                    sq_vld_ff  [LSTEPS+1];

   always_ff @(posedge clock) begin
      if (reset) sq_vld_ff[0] <= 1'b0;
      else sq_vld_ff[0] <= b_vld_ff;
   end
   always_ff @(posedge clock) begin
      sq_v_ff[0]    <= unsigned'(b_sqx_ff) + unsigned'(b_sqy_ff) + unsigned'(b_sqz_ff);
      sq_r_ff[0]    <= '0;
      sq_item_ff[0] <= b_item_ff;
   end

   for (genvar k = 0; k < LSTEPS; k++) begin : g_len_root
      localparam logic [SS_W:0] BIT = (SS_W+1)'(1) << (2 * (LSTEPS - 1 - k));
      logic [SS_W:0] trial;
      logic          take;
      assign trial = sq_r_ff[k] + BIT;
      assign take  = {1'b0, sq_v_ff[k]} >= trial;
      always_ff @(posedge clock) begin
         if (reset) sq_vld_ff[k+1] <= 1'b0;
         else sq_vld_ff[k+1] <= sq_vld_ff[k];
      end
      always_ff @(posedge clock) begin
         sq_item_ff[k+1] <= sq_item_ff[k];
         if (take) begin
            sq_v_ff[k+1] <= sq_v_ff[k] - trial[SS_W-1:0];
            sq_r_ff[k+1] <= (sq_r_ff[k] >> 1) + BIT;
         end else begin
            sq_v_ff[k+1] <= sq_v_ff[k];
            sq_r_ff[k+1] <= sq_r_ff[k] >> 1;
         end
      end
   end

   // round the length, then divide each |d| by it; index 0 holds the rounded length
   logic [DIVR_W-1:0]  dv_rem_ff  [QBITS+1][3];
   logic [QBITS-1:0]   dv_quo_ff  [QBITS+1][3];
   baas_pkg::item_type dv_item_ff [QBITS+1];
   logic               dv_vld_ff  [QBITS+1];

   baas_pkg::item_type dv_item_in;
   logic [DIVR_W-1:0]  dv_rem_in [3];
   logic [DIFF_W-1:0]  mag_in [3];
   always_comb begin
      dv_item_in     = sq_item_ff[LSTEPS];
      // remainder above the root means the true root is nearer the next integer
      dv_item_in.len = LEN_W'(sq_r_ff[LSTEPS])
                     + LEN_W'({1'b0, sq_v_ff[LSTEPS]} > sq_r_ff[LSTEPS]);
      mag_in[0] = dv_item_in.dx[DIFF_W-1] ? DIFF_W'(-dv_item_in.dx) : DIFF_W'(dv_item_in.dx);
      mag_in[1] = dv_item_in.dy[DIFF_W-1] ? DIFF_W'(-dv_item_in.dy) : DIFF_W'(dv_item_in.dy);
      mag_in[2] = dv_item_in.dz[DIFF_W-1] ? DIFF_W'(-dv_item_in.dz) : DIFF_W'(dv_item_in.dz);
      for (int c = 0; c < 3; c++) begin
         dv_rem_in[c] = (DIVR_W'(mag_in[c]) << FRAC) + DIVR_W'(dv_item_in.len >> 1);
      end
   end
   always_ff @(posedge clock) begin
      if (reset) dv_vld_ff[0] <= 1'b0;
      else dv_vld_ff[0] <= sq_vld_ff[LSTEPS];
   end
   always_ff @(posedge clock) begin
      dv_item_ff[0] <= dv_item_in;
      for (int c = 0; c < 3; c++) begin
         dv_rem_ff[0][c] <= dv_rem_in[c];
         dv_quo_ff[0][c] <= '0;
      end
   end

   for (genvar j = 0; j < QBITS; j++) begin : g_div
      localparam int B = QBITS - 1 - j;
      logic [DIVR_W-1:0] dsh;
      assign dsh = DIVR_W'(dv_item_ff[j].len) << B;
      always_ff @(posedge clock) begin
         if (reset) dv_vld_ff[j+1] <= 1'b0;
         else dv_vld_ff[j+1] <= dv_vld_ff[j];
      end
      for (genvar c = 0; c < 3; c++) begin : g_comp
         always_ff @(posedge clock) begin
            if (dv_rem_ff[j][c] >= dsh) begin
               dv_rem_ff[j+1][c]    <= dv_rem_ff[j][c] - dsh;
               dv_quo_ff[j+1][c]    <= dv_quo_ff[j][c] | (QBITS'(1) << B);
            end else begin
               dv_rem_ff[j+1][c]    <= dv_rem_ff[j][c];
               dv_quo_ff[j+1][c]    <= dv_quo_ff[j][c];
            end
         end
      end
      always_ff @(posedge clock) begin
         dv_item_ff[j+1] <= dv_item_ff[j];
      end
   end

   // direction, pole test and 1 - z^2 for the acos root; index 0 of that root chain
   logic [ACOS_W-1:0]  ac_v_ff    [ASTEPS+1];
   logic [ACOS_W:0]    ac_r_ff    [ASTEPS+1];
   baas_pkg::item_type ac_item_ff [ASTEPS+1];
   logic               ac_vld_ff  [ASTEPS+1];

   baas_pkg::item_type          p_item_in;
   logic [QBITS-1:0]            q_sat [3];
   logic signed [UNIT_W-1:0]    u_in  [3];
   logic [baas_pkg::ZSQ_W-1:0]  zsq_in;
   logic [ACOS_W-1:0]           p_rem_in;
   logic                        neg   [3];
   always_comb begin
      p_item_in = dv_item_ff[QBITS];
      neg[0] = p_item_in.dx[DIFF_W-1];
      neg[1] = p_item_in.dy[DIFF_W-1];
      neg[2] = p_item_in.dz[DIFF_W-1];
      for (int c = 0; c < 3; c++) begin
         if (p_item_in.len == '0) q_sat[c] = '0;
         else if (dv_quo_ff[QBITS][c] > (QBITS'(1) << FRAC)) q_sat[c] = QBITS'(1) << FRAC;
         else q_sat[c] = dv_quo_ff[QBITS][c];
         u_in[c] = neg[c] ? -UNIT_W'(q_sat[c]) : UNIT_W'(q_sat[c]);
      end
      p_item_in.ux       = u_in[0];
      p_item_in.uy       = u_in[1];
      p_item_in.uz       = u_in[2];
      p_item_in.pole     = q_sat[2] > thr_ff;
      p_item_in.pole_neg = u_in[2] < 0;
      zsq_in   = baas_pkg::ZSQ_W'(q_sat[2]) * baas_pkg::ZSQ_W'(q_sat[2]);
      p_rem_in = ACOS_W'((baas_pkg::ZSQ_W'(1) << (2 * FRAC)) - zsq_in)
               << baas_pkg::ACOS_SHIFT;
   end
   always_ff @(posedge clock) begin
      if (reset) ac_vld_ff[0] <= 1'b0;
      else ac_vld_ff[0] <= dv_vld_ff[QBITS];
   end
   always_ff @(posedge clock) begin
      ac_item_ff[0] <= p_item_in;
      ac_v_ff[0]    <= p_rem_in;
      ac_r_ff[0]    <= '0;
   end

   for (genvar k = 0; k < ASTEPS; k++) begin : g_acos_root
      localparam logic [ACOS_W:0] BIT = (ACOS_W+1)'(1) << (2 * (ASTEPS - 1 - k));
      logic [ACOS_W:0] trial;
      logic            take;
      assign trial = ac_r_ff[k] + BIT;
      assign take  = {1'b0, ac_v_ff[k]} >= trial;
      always_ff @(posedge clock) begin
         if (reset) ac_vld_ff[k+1] <= 1'b0;
         else ac_vld_ff[k+1] <= ac_vld_ff[k];
      end
      always_ff @(posedge clock) begin
         ac_item_ff[k+1] <= ac_item_ff[k];
         if (take) begin
            ac_v_ff[k+1] <= ac_v_ff[k] - trial[ACOS_W-1:0];
            ac_r_ff[k+1] <= (ac_r_ff[k] >> 1) + BIT;
         end else begin
            ac_v_ff[k+1] <= ac_v_ff[k];
            ac_r_ff[k+1] <= ac_r_ff[k] >> 1;
         end
      end
   end

   // cordic vectoring for atan2(root, z); index 0 is the quadrant fold
   logic signed [CRD_W-1:0] cr_x_ff    [CSTEPS+1];
   logic signed [CRD_W-1:0] cr_y_ff    [CSTEPS+1];
   logic signed [ANG_W-1:0] cr_a_ff    [CSTEPS+1];
   baas_pkg::item_type      cr_item_ff [CSTEPS+1];
   logic                    cr_vld_ff  [CSTEPS+1];

   logic signed [CRD_W-1:0] x0_in, y0_in;
   always_comb begin
      x0_in = CRD_W'(ac_item_ff[ASTEPS].uz) <<< baas_pkg::Z_SHIFT;
      y0_in = CRD_W'(ac_r_ff[ASTEPS]);
   end
   always_ff @(posedge clock) begin
      if (reset) cr_vld_ff[0] <= 1'b0;
      else cr_vld_ff[0] <= ac_vld_ff[ASTEPS];
   end
   always_ff @(posedge clock) begin
      cr_item_ff[0] <= ac_item_ff[ASTEPS];
      // left half plane: rotate by -90 degrees first
      if (x0_in < 0) begin
         cr_x_ff[0] <= y0_in;
         cr_y_ff[0] <= -x0_in;
         cr_a_ff[0] <= baas_pkg::HALF_PI_Q60;
      end else begin
         cr_x_ff[0] <= x0_in;
         cr_y_ff[0] <= y0_in;
         cr_a_ff[0] <= '0;
      end
   end

   for (genvar i = 0; i < CSTEPS; i++) begin : g_cordic
      localparam logic signed [ANG_W-1:0] ATAN_I = baas_pkg::atan_q60(i);
      logic signed [CRD_W-1:0] xs, ys;
      assign xs = cr_x_ff[i] >>> i;
      assign ys = cr_y_ff[i] >>> i;
      always_ff @(posedge clock) begin
         if (reset) cr_vld_ff[i+1] <= 1'b0;
         else cr_vld_ff[i+1] <= cr_vld_ff[i];
      end
      always_ff @(posedge clock) begin
         cr_item_ff[i+1] <= cr_item_ff[i];
         if (cr_y_ff[i] > 0) begin
            cr_x_ff[i+1] <= cr_x_ff[i] + ys;
            cr_y_ff[i+1] <= cr_y_ff[i] - xs;
            cr_a_ff[i+1] <= cr_a_ff[i] + ATAN_I;
         end else begin
            cr_x_ff[i+1] <= cr_x_ff[i] - ys;
            cr_y_ff[i+1] <= cr_y_ff[i] + xs;
            cr_a_ff[i+1] <= cr_a_ff[i] - ATAN_I;
         end
      end
   end

   // output stage: clamp and round the angle, pick pole or regular axis
   baas_pkg::item_type              o_item;
   logic signed [ANG_W-1:0]         ang_clamp;
   logic signed [ANG_W-1:0]         ang_round;
   logic signed [UNIT_W-1:0]        axis_x_in, axis_y_in, axis_z_in;
   logic signed [baas_pkg::ANGLE_W-1:0] angle_in;
   always_comb begin
      o_item = cr_item_ff[CSTEPS];
      if (cr_a_ff[CSTEPS] < 0) ang_clamp = '0;
      else if (cr_a_ff[CSTEPS] > baas_pkg::PI_Q60) ang_clamp = baas_pkg::PI_Q60;
      else ang_clamp = cr_a_ff[CSTEPS];
      ang_round = (ang_clamp + baas_pkg::ANG_ROUND) >>> (60 - FRAC);
      if (o_item.pole && o_item.pole_neg) begin
         axis_x_in = '0;
         axis_y_in = baas_pkg::UNIT_ONE;
         axis_z_in = '0;
         angle_in  = baas_pkg::POLE_NEG_ANGLE;
      end else if (o_item.pole) begin
         axis_x_in = '0;
         axis_y_in = '0;
         axis_z_in = baas_pkg::UNIT_ONE;
         angle_in  = '0;
      end else begin
         axis_x_in = -o_item.uy;
         axis_y_in = o_item.ux;
         axis_z_in = '0;
         angle_in  = baas_pkg::ANGLE_W'(ang_round);
      end
   end

   logic                                out_vld_ff;
   logic [baas_pkg::OUT_LEN_W-1:0]      out_len_ff;
   logic signed [UNIT_W-1:0]            out_ux_ff, out_uy_ff, out_uz_ff;
   logic signed [UNIT_W-1:0]            out_ax_ff, out_ay_ff, out_az_ff;
   logic signed [baas_pkg::ANGLE_W-1:0] out_ang_ff;
   logic [baas_pkg::ID_W-1:0]           out_id1_ff, out_id2_ff;
   always_ff @(posedge clock) begin
      if (reset) out_vld_ff <= 1'b0;
      else out_vld_ff <= cr_vld_ff[CSTEPS];
   end
   always_ff @(posedge clock) begin
      out_len_ff <= o_item.len[baas_pkg::OUT_LEN_W-1:0];
      out_ux_ff  <= o_item.ux;
      out_uy_ff  <= o_item.uy;
      out_uz_ff  <= o_item.uz;
      out_ax_ff  <= axis_x_in;
      out_ay_ff  <= axis_y_in;
      out_az_ff  <= axis_z_in;
      out_ang_ff <= angle_in;
      out_id1_ff <= o_item.first_id;
      out_id2_ff <= o_item.second_id;
   end
   assign rsp_valid         = out_vld_ff;
   assign rsp_bond_length   = out_len_ff;
   assign rsp_dir_x         = out_ux_ff;
   assign rsp_dir_y         = out_uy_ff;
   assign rsp_dir_z         = out_uz_ff;
   assign rsp_axis_x        = out_ax_ff;
   assign rsp_axis_y        = out_ay_ff;
   assign rsp_axis_z        = out_az_ff;
   assign rsp_rot_angle     = out_ang_ff;
   assign rsp_out_first_id  = out_id1_ff;
   assign rsp_out_second_id = out_id2_ff;

endmodule

@@ verif/tb_bond_axis_angle_setup.sv @@
// testbench for bond_axis_angle_setup: directed and random bonds, checked against a local predictor
// depends on baas_pkg and the bond_axis_angle_setup rtl
module tb_bond_axis_angle_setup;

   typedef struct {
      logic signed [baas_pkg::POS_W-1:0] p1x, p1y, p1z, p2x, p2y, p2z;
      logic [baas_pkg::ID_W-1:0]         id1, id2;
   } bond_word_type;

   typedef struct {
      logic [baas_pkg::OUT_LEN_W-1:0]      len;
      logic signed [baas_pkg::UNIT_W-1:0]  ux, uy, uz, ax, ay, az;
      logic signed [baas_pkg::ANGLE_W-1:0] ang;
      logic [baas_pkg::ID_W-1:0]           id1, id2;
   } pose_type;

   localparam longint unsigned PI60 = 64'h3243F6A8885A308D;
   localparam int LIMIT = 4000;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   bond_word_type cur = '{default: 0};
   logic rsp_valid;
   logic [baas_pkg::OUT_LEN_W-1:0] rsp_bond_length;
   logic signed [baas_pkg::UNIT_W-1:0] rsp_dir_x, rsp_dir_y, rsp_dir_z;
   logic signed [baas_pkg::UNIT_W-1:0] rsp_axis_x, rsp_axis_y, rsp_axis_z;
   logic signed [baas_pkg::ANGLE_W-1:0] rsp_rot_angle;
   logic [baas_pkg::ID_W-1:0] rsp_out_first_id, rsp_out_second_id;
   logic csr_valid = 0;
   logic csr_ready;
   logic [baas_pkg::THR_W-1:0] csr_data = '0;

   bond_word_type pending[$];
   pose_type      expected_poses[$];
   longint unsigned threshold = 65470;
   int send_idle_pct = 0;
   int errors = 0;
   int quiet = 0;
   logic csr_taken = 0;

   bond_axis_angle_setup dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_first_x(cur.p1x), .req_first_y(cur.p1y), .req_first_z(cur.p1z),
      .req_second_x(cur.p2x), .req_second_y(cur.p2y), .req_second_z(cur.p2z),
      .req_first_atom_id(cur.id1), .req_second_atom_id(cur.id2),
      .rsp_valid(rsp_valid), .rsp_bond_length(rsp_bond_length),
      .rsp_dir_x(rsp_dir_x), .rsp_dir_y(rsp_dir_y), .rsp_dir_z(rsp_dir_z),
      .rsp_axis_x(rsp_axis_x), .rsp_axis_y(rsp_axis_y), .rsp_axis_z(rsp_axis_z),
      .rsp_rot_angle(rsp_rot_angle), .rsp_out_first_id(rsp_out_first_id),
      .rsp_out_second_id(rsp_out_second_id),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always #2 clock = ~clock;

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint arctan_step(int i);
      longint s;
      longint unsigned p, k;
      s = 0;
      k = 0;
      if (i == 0) return longint'(PI60 / 4);
      p = 64'd1 << (60 - i);
      while (p != 0) begin
         if (k[0]) s = s - longint'(p / (2 * k + 1));
         else      s = s + longint'(p / (2 * k + 1));
         p = p >> (2 * i);
         k++;
      end
      return s;
   endfunction

   function automatic longint arccos_q16(longint z);
      longint x, y, a, t, xs, ys;
      longint unsigned rem;
      rem = longint'((64'sd65536 * 64'sd65536) - z * z) << 28;
      x = z <<< 14;
      y = longint'(int_sqrt(rem));
      a = 0;
      if (x < 0) begin
         t = x;
         x = y;
         y = -t;
         a = longint'(PI60 / 2);
      end
      for (int i = 0; i < 31; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x = x + ys; y = y - xs; a = a + arctan_step(i);
         end else begin
            x = x - ys; y = y + xs; a = a - arctan_step(i);
         end
      end
      if (a < 0) a = 0;
      if (a > longint'(PI60)) a = longint'(PI60);
      return (a + (64'sd1 <<< 43)) >>> 44;
   endfunction

   function automatic longint unit_part(longint d, longint unsigned len);
      longint unsigned m, q;
      m = (d < 0) ? longint'(-d) : d;
      if (len == 0) return 0;
      q = ((m << 16) + len / 2) / len;
      if (q > 65536) q = 65536;
      return (d < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic pose_type predict_pose(bond_word_type w);
      pose_type r;
      longint dx, dy, dz, ux, uy, uz, az_abs;
      longint unsigned ss, len;
      dx = longint'(w.p2x) - longint'(w.p1x);
      dy = longint'(w.p2y) - longint'(w.p1y);
      dz = longint'(w.p2z) - longint'(w.p1z);
      ss = dx * dx + dy * dy + dz * dz;
      len = int_sqrt(ss);
      if (ss - len * len > len) len++;
      ux = unit_part(dx, len);
      uy = unit_part(dy, len);
      uz = unit_part(dz, len);
      az_abs = (uz < 0) ? -uz : uz;
      r.len = len[baas_pkg::OUT_LEN_W-1:0];
      r.ux = ux[baas_pkg::UNIT_W-1:0];
      r.uy = uy[baas_pkg::UNIT_W-1:0];
      r.uz = uz[baas_pkg::UNIT_W-1:0];
      r.id1 = w.id1;
      r.id2 = w.id2;
      if (unsigned'(az_abs) > threshold) begin
         r.ax = '0;
         if (uz < 0) begin
            r.ay = baas_pkg::UNIT_W'(65536); r.az = '0;
            r.ang = baas_pkg::ANGLE_W'(-((longint'(PI60) + (64'sd1 <<< 43)) >>> 44));
         end else begin
            r.ay = '0; r.az = baas_pkg::UNIT_W'(65536); r.ang = '0;
         end
      end else begin
         r.ax = baas_pkg::UNIT_W'(-uy);
         r.ay = baas_pkg::UNIT_W'(ux);
         r.az = '0;
         r.ang = baas_pkg::ANGLE_W'(arccos_q16(uz));
      end
      return r;
   endfunction

   // driver: one word per handshake, random gaps
   always @(posedge clock) begin
      bond_word_type nxt;
      if (start && !busy) expected_poses.push_back(predict_pose(cur));
      if (reset || (start && busy)) begin
         // hold current word until it is taken
      end else if (pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
         nxt = pending.pop_front();
         cur <= nxt;
         start <= 1;
      end else begin
         start <= 0;
      end
   end

   task automatic check_field(string name, longint e, longint a);
      if (e != a) begin
         $error("%s expected %0d got %0d", name, e, a);
         errors++;
      end
   endtask

   // monitor
   always @(posedge clock) begin
      pose_type e;
      if (!reset && rsp_valid) begin
         if (expected_poses.size() == 0) begin
            $error("result word with nothing expected");
            errors++;
         end else begin
            e = expected_poses.pop_front();
            check_field("bond_length", e.len, rsp_bond_length);
            check_field("dir_x", e.ux, rsp_dir_x);
            check_field("dir_y", e.uy, rsp_dir_y);
            check_field("dir_z", e.uz, rsp_dir_z);
            check_field("axis_x", e.ax, rsp_axis_x);
            check_field("axis_y", e.ay, rsp_axis_y);
            check_field("axis_z", e.az, rsp_axis_z);
            check_field("rot_angle", e.ang, rsp_rot_angle);
            check_field("out_first_id", e.id1, rsp_out_first_id);
            check_field("out_second_id", e.id2, rsp_out_second_id);
         end
      end
   end

   // watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_taken) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   task automatic wait_drained();
      while (pending.size() != 0 || expected_poses.size() != 0 || start) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   task automatic write_threshold(logic [baas_pkg::THR_W-1:0] v);
      csr_valid <= 1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      threshold = v;
      csr_valid <= 0;
      csr_taken <= 1;
      @(posedge clock);
      csr_taken <= 0;
   endtask

   function automatic logic signed [baas_pkg::POS_W-1:0] rnd_pos();
      return baas_pkg::POS_W'($urandom);
   endfunction

   task automatic add_bond(longint x1, longint y1, longint z1, longint x2, longint y2,
                           longint z2);
      bond_word_type w;
      w.p1x = baas_pkg::POS_W'(x1); w.p1y = baas_pkg::POS_W'(y1);
      w.p1z = baas_pkg::POS_W'(z1);
      w.p2x = baas_pkg::POS_W'(x2); w.p2y = baas_pkg::POS_W'(y2);
      w.p2z = baas_pkg::POS_W'(z2);
      w.id1 = baas_pkg::ID_W'($urandom);
      w.id2 = baas_pkg::ID_W'($urandom);
      pending.push_back(w);
   endtask

   task automatic add_random(int n);
      bond_word_type w;
      int pick;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(9);
         w.p1x = rnd_pos(); w.p1y = rnd_pos(); w.p1z = rnd_pos();
         w.id1 = baas_pkg::ID_W'($urandom); w.id2 = baas_pkg::ID_W'($urandom);
         if (pick < 4) begin
            w.p2x = rnd_pos(); w.p2y = rnd_pos(); w.p2z = rnd_pos();
         end else if (pick < 7) begin
            // nearly along z, to land on and around the pole threshold
            w.p2x = baas_pkg::POS_W'(w.p1x + $signed($urandom_range(4000)) - 2000);
            w.p2y = baas_pkg::POS_W'(w.p1y + $signed($urandom_range(4000)) - 2000);
            w.p2z = baas_pkg::POS_W'(w.p1z + (($urandom_range(1)) ? 1 : -1)
                                     * $signed($urandom_range(200000, 20)));
         end else if (pick < 9) begin
            w.p2x = baas_pkg::POS_W'(w.p1x + $signed($urandom_range(64)) - 32);
            w.p2y = baas_pkg::POS_W'(w.p1y + $signed($urandom_range(64)) - 32);
            w.p2z = baas_pkg::POS_W'(w.p1z + $signed($urandom_range(64)) - 32);
         end else begin
            w.p2x = w.p1x; w.p2y = w.p1y; w.p2z = w.p1z;
         end
         pending.push_back(w);
      end
   endtask

   initial begin
      logic [baas_pkg::THR_W-1:0] thr[5];
      int idle[5];
      bond_word_type w;
      thr = '{17'd65470, 17'd0, 17'd65536, 17'd65535, 17'($urandom_range(65536))};
      idle = '{0, 71, 0, 23, 71};
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed words
      add_bond(5, 6, 7, 5, 6, 7);
      add_bond(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607);
      add_bond(8388607, 8388607, 8388607, -8388608, -8388608, -8388608);
      add_bond(0, 0, -8388608, 0, 0, 8388607);
      add_bond(0, 0, 8388607, 0, 0, -8388608);
      add_bond(0, 0, 0, 65536, 0, 0);
      add_bond(0, 0, 0, 0, -65536, 0);
      add_bond(0, 0, 0, 0, 0, 1);
      add_bond(0, 0, 0, 0, 0, -1);
      add_bond(0, 0, 0, 1000, 0, 22330);
      add_bond(0, 0, 0, -1000, 0, -22330);
      add_bond(0, 0, 0, 1, 1, 0);
      add_bond(-8388608, 0, 0, 8388607, 0, 0);
      w.p1x = '0; w.p1y = '0; w.p1z = '0;
      w.p2x = 24'sd3; w.p2y = 24'sd4; w.p2z = '0;
      w.id1 = 16'hFFFF; w.id2 = 16'h0000;
      pending.push_back(w);
      w.id1 = 16'h0000; w.id2 = 16'hFFFF;
      pending.push_back(w);

      for (int ph = 0; ph < 5; ph++) begin
         wait_drained();
         write_threshold(thr[ph]);
         send_idle_pct = idle[ph];
         add_random(145);
         // sender pauses mid phase until every result is back
         wait_drained();
         add_random(145);
      end
      wait_drained();
      if (errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
